>>> rtl/core/clcd_pkg.sv
package clcd_pkg;

  localparam int PcW = 6;
  localparam int RomDepth = 37;

  localparam logic [PcW-1:0] EntryByte  = 6'd0;
  localparam logic [PcW-1:0] EntryClear = 6'd4;
  localparam logic [PcW-1:0] EntryInit  = 6'd9;

  localparam logic [7:0] CmdClear  = 8'h01;
  localparam logic [7:0] CursorBit = 8'h80;

  typedef enum logic [2:0] {
    KIND_CMD    = 3'd0,
    KIND_DATA   = 3'd1,
    KIND_CURSOR = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_INIT   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    NIB_HELD  = 2'd0,
    NIB_HI    = 2'd1,
    NIB_LO    = 2'd2,
    NIB_CONST = 2'd3
  } nib_sel_e;

  typedef enum logic [1:0] {
    RS_HELD = 2'd0,
    RS_REQ  = 2'd1,
    RS_ZERO = 2'd2
  } rs_sel_e;

  typedef struct packed {
    logic       en;
    nib_sel_e   nib;
    logic [3:0] cnib;
    rs_sel_e    rs;
    logic [5:0] hold;
    logic       last;
  } ctrl_word_t;

  function automatic ctrl_word_t mk(logic en, nib_sel_e nib, logic [3:0] cnib,
                                    rs_sel_e rs, logic [5:0] hold, logic last);
    ctrl_word_t w;
    w.en   = en;
    w.nib  = nib;
    w.cnib = cnib;
    w.rs   = rs;
    w.hold = hold;
    w.last = last;
    return w;
  endfunction

  function automatic ctrl_word_t nib_word(logic en, logic [3:0] cnib, logic last);
    return mk(en, NIB_CONST, cnib, RS_ZERO, 6'd1, last);
  endfunction

  function automatic ctrl_word_t wait_word(logic [5:0] hold, logic last);
    return mk(1'b0, NIB_HELD, 4'h0, RS_HELD, hold, last);
  endfunction

  function automatic ctrl_word_t rom_word(logic [PcW-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      // byte request: command, data, cursor
      6'd0:  w = mk(1'b1, NIB_HI, 4'h0, RS_REQ, 6'd1, 1'b0);
      6'd1:  w = mk(1'b0, NIB_HI, 4'h0, RS_REQ, 6'd1, 1'b0);
      6'd2:  w = mk(1'b1, NIB_LO, 4'h0, RS_REQ, 6'd1, 1'b0);
      6'd3:  w = mk(1'b0, NIB_LO, 4'h0, RS_REQ, 6'd1, 1'b1);
      // clear
      6'd4:  w = mk(1'b1, NIB_HI, 4'h0, RS_REQ, 6'd1, 1'b0);
      6'd5:  w = mk(1'b0, NIB_HI, 4'h0, RS_REQ, 6'd1, 1'b0);
      6'd6:  w = mk(1'b1, NIB_LO, 4'h0, RS_REQ, 6'd1, 1'b0);
      6'd7:  w = mk(1'b0, NIB_LO, 4'h0, RS_REQ, 6'd1, 1'b0);
      6'd8:  w = wait_word(6'd2, 1'b1);
      // power-up init
      6'd9:  w = wait_word(6'd50, 1'b0);
      6'd10: w = nib_word(1'b1, 4'h3, 1'b0);
      6'd11: w = nib_word(1'b0, 4'h3, 1'b0);
      6'd12: w = wait_word(6'd5, 1'b0);
      6'd13: w = nib_word(1'b1, 4'h3, 1'b0);
      6'd14: w = nib_word(1'b0, 4'h3, 1'b0);
      6'd15: w = wait_word(6'd1, 1'b0);
      6'd16: w = nib_word(1'b1, 4'h3, 1'b0);
      6'd17: w = nib_word(1'b0, 4'h3, 1'b0);
      6'd18: w = nib_word(1'b1, 4'h2, 1'b0);
      6'd19: w = nib_word(1'b0, 4'h2, 1'b0);
      6'd20: w = nib_word(1'b1, 4'h2, 1'b0);
      6'd21: w = nib_word(1'b0, 4'h2, 1'b0);
      6'd22: w = nib_word(1'b1, 4'h8, 1'b0);
      6'd23: w = nib_word(1'b0, 4'h8, 1'b0);
      6'd24: w = nib_word(1'b1, 4'h0, 1'b0);
      6'd25: w = nib_word(1'b0, 4'h0, 1'b0);
      6'd26: w = nib_word(1'b1, 4'hC, 1'b0);
      6'd27: w = nib_word(1'b0, 4'hC, 1'b0);
      6'd28: w = nib_word(1'b1, 4'h0, 1'b0);
      6'd29: w = nib_word(1'b0, 4'h0, 1'b0);
      6'd30: w = nib_word(1'b1, 4'h6, 1'b0);
      6'd31: w = nib_word(1'b0, 4'h6, 1'b0);
      6'd32: w = nib_word(1'b1, 4'h0, 1'b0);
      6'd33: w = nib_word(1'b0, 4'h0, 1'b0);
      6'd34: w = nib_word(1'b1, 4'h1, 1'b0);
      6'd35: w = nib_word(1'b0, 4'h1, 1'b0);
      6'd36: w = wait_word(6'd2, 1'b1);
      default: w = wait_word(6'd1, 1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [7:0] row_base(logic [1:0] row);
    logic [7:0] b;
    unique case (row)
      2'd0: b = 8'h00;
      2'd1: b = 8'h40;
      2'd2: b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/char_lcd_4bit_sequencer.sv
// the first segment word of a request is registered at the output after the program counter is loaded
// throughput: one segment per cycle while the output is not stalled; 4 segments for a byte, 5 for clear, 28 for init
// one request at a time, the program counter walks a 37-step control rom
// a new request is taken in the cycle after the last segment is issued
// reset clears the sequencer, the output valid and the held rs and data lines
module char_lcd_4bit_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  input  logic [7:0] value_i,
  input  logic [1:0] row_i,
  input  logic [5:0] col_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       rs_o,
  output logic       en_o,
  output logic [3:0] data_lines_o,
  output logic [5:0] hold_ms_o,
  output logic       last_o
);

  logic                       busy_q, busy_d;
  logic [clcd_pkg::PcW-1:0]   pc_q, pc_d;
  logic                       out_valid_q, out_valid_d;
  logic                       accept, load, step;
  logic                       load_rs;
  logic [7:0]                 load_byte;
  logic [clcd_pkg::PcW-1:0]   entry;
  clcd_pkg::ctrl_word_t       cw;

  assign accept = in_valid_i && !busy_q;
  assign step   = busy_q && (!out_valid_q || !out_stall_i);
  assign cw     = clcd_pkg::rom_word(pc_q);

  always_comb begin
    load      = 1'b0;
    load_rs   = 1'b0;
    load_byte = value_i;
    entry     = clcd_pkg::EntryByte;
    unique case (kind_i)
      clcd_pkg::KIND_CMD: begin
        load = accept;
      end
      clcd_pkg::KIND_DATA: begin
        load    = accept;
        load_rs = 1'b1;
      end
      clcd_pkg::KIND_CURSOR: begin
        load      = accept;
        load_byte = clcd_pkg::CursorBit | (clcd_pkg::row_base(row_i) + {2'b00, col_i});
      end
      clcd_pkg::KIND_CLEAR: begin
        load      = accept;
        load_byte = clcd_pkg::CmdClear;
        entry     = clcd_pkg::EntryClear;
      end
      clcd_pkg::KIND_INIT: begin
        load  = accept;
        entry = clcd_pkg::EntryInit;
      end
      default: load = 1'b0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (step) begin
      out_valid_d = 1'b1;
      pc_d        = pc_q + 1'b1;
      if (cw.last) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      pc_d   = entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  clcd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .load_rs_i    (load_rs),
    .load_byte_i  (load_byte),
    .step_i       (step),
    .cw_i         (cw),
    .rs_o         (rs_o),
    .en_o         (en_o),
    .data_lines_o (data_lines_o),
    .hold_ms_o    (hold_ms_o),
    .last_o       (last_o)
  );

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q && !in_stall_o == 1'b0)
    else $error("request taken but sequencer not busy");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && cw.last |=> !busy_q && out_valid_o && last_o)
    else $error("last segment did not end the request");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q < 6'(clcd_pkg::RomDepth))
    else $error("program counter past end of control rom");

  a_hold_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hold_ms_o != 6'd0)
    else $error("segment word with zero hold time");

endmodule

>>> rtl/core/clcd_datapath.sv
module clcd_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic                  load_rs_i,
  input  logic [7:0]            load_byte_i,
  input  logic                  step_i,
  input  clcd_pkg::ctrl_word_t  cw_i,
  output logic                  rs_o,
  output logic                  en_o,
  output logic [3:0]            data_lines_o,
  output logic [5:0]            hold_ms_o,
  output logic                  last_o
);

  logic [7:0] byte_q;
  logic       req_rs_q;
  logic [3:0] held_lines_q, held_lines_d;
  logic       held_rs_q, held_rs_d;
  logic       rs_q, en_q, last_q;
  logic [3:0] lines_q;
  logic [5:0] hold_q;

  always_comb begin
    held_lines_d = held_lines_q;
    held_rs_d    = held_rs_q;
    unique case (cw_i.nib)
      clcd_pkg::NIB_HELD:  held_lines_d = held_lines_q;
      clcd_pkg::NIB_HI:    held_lines_d = byte_q[7:4];
      clcd_pkg::NIB_LO:    held_lines_d = byte_q[3:0];
      clcd_pkg::NIB_CONST: held_lines_d = cw_i.cnib;
      default:             held_lines_d = held_lines_q;
    endcase
    unique case (cw_i.rs)
      clcd_pkg::RS_HELD: held_rs_d = held_rs_q;
      clcd_pkg::RS_REQ:  held_rs_d = req_rs_q;
      clcd_pkg::RS_ZERO: held_rs_d = 1'b0;
      default:           held_rs_d = held_rs_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_lines_q <= 4'h0;
      held_rs_q    <= 1'b0;
    end else if (step_i) begin
      held_lines_q <= held_lines_d;
      held_rs_q    <= held_rs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q   <= load_byte_i;
      req_rs_q <= load_rs_i;
    end
    if (step_i) begin
      rs_q    <= held_rs_d;
      en_q    <= cw_i.en;
      lines_q <= held_lines_d;
      hold_q  <= cw_i.hold;
      last_q  <= cw_i.last;
    end
  end

  assign rs_o         = rs_q;
  assign en_o         = en_q;
  assign data_lines_o = lines_q;
  assign hold_ms_o    = hold_q;
  assign last_o       = last_q;

endmodule
